/* rtl/text_console_writer_macros.svh */
// Assertion helpers used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] NEWLINE_CODE     = 8'd10;
    localparam logic [7:0] SPACE_CODE       = 8'd32;
    localparam logic [7:0] CLEAR_ATTR_RESET = 8'd15;

    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_PUT_AT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] character;
        logic [7:0] attribute;
        logic [6:0] column;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_cell;
        logic [7:0]  read_character;
        logic [7:0]  read_attribute;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_PUT,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc_addr;
        logic put;
        logic sweep_fill;
        logic fill_clear;
        logic scroll;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       sweep_last;
        logic       need_scroll;
    } t_ctrl_status;

endpackage

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  logic         i_stall,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   can_load;

    assign accept   = (r_state == ST_IDLE) && i_valid;
    assign can_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:   if (i_status.sweep_last) n_state = ST_IDLE;
            ST_IDLE:   if (accept) n_state = ST_ADDR;
            ST_ADDR: begin
                unique case (i_status.kind) inside
                    KIND_PUT, KIND_PUT_AT: n_state = ST_PUT;
                    KIND_CLEAR:            n_state = ST_CLEAR;
                    default:               n_state = ST_READ;
                endcase
            end
            ST_PUT:    n_state = i_status.need_scroll ? ST_SCROLL : ST_DONE;
            ST_READ:   n_state = ST_DONE;
            ST_CLEAR:  if (i_status.sweep_last) n_state = ST_DONE;
            ST_SCROLL: if (i_status.sweep_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DONE;
            ST_DONE:   if (can_load) n_state = ST_IDLE;
            default:   n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_stall          = (r_state != ST_IDLE);
        o_cmd.capture    = accept;
        o_cmd.load_out   = can_load;
        unique case (r_state)
            ST_INIT:   o_cmd.sweep_fill = 1'b1;
            ST_ADDR:   o_cmd.calc_addr  = 1'b1;
            ST_PUT:    o_cmd.put        = 1'b1;
            ST_CLEAR: begin
                o_cmd.sweep_fill = 1'b1;
                o_cmd.fill_clear = 1'b1;
            end
            ST_SCROLL: o_cmd.scroll     = 1'b1;
            default: ;
        endcase
    end

    // Result register empties when taken, refills when an item finishes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (can_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/tcw_datapath.sv */
`timescale 1ns / 1ps
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_in_item     i_item,
    output t_out_item    o_item,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  t_ctrl_cmd    i_cmd,
    output t_ctrl_status o_status
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int MOVE_CELLS = CELLS - COLUMNS;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic [7:0]        r_clear_attr;
    logic [1:0]        r_kind;
    logic [7:0]        r_char;
    logic [7:0]        r_attr;
    logic [COL_W-1:0]  r_tcol;
    logic [ROW_W-1:0]  r_trow;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_sc_valid;
    logic              r_sc_zero;
    logic [ADDR_W-1:0] r_sc_addr;
    t_out_item         r_out;

    logic              sweep_last;
    logic              wrap_col;
    logic              last_row;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              sweep_moves;

    assign sweep_last  = (r_sweep == ADDR_W'(CELLS - 1));
    assign sweep_moves = (32'(r_sweep) < 32'(MOVE_CELLS));
    assign wrap_col    = (r_char == NEWLINE_CODE) || (r_tcol == COL_W'(COLUMNS - 1));
    assign last_row    = (r_trow == ROW_W'(ROWS - 1));

    assign o_status.kind        = r_kind;
    assign o_status.sweep_last  = sweep_last;
    assign o_status.need_scroll = wrap_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_attr <= CLEAR_ATTR_RESET;
        end else if (i_cfg_we) begin
            r_clear_attr <= i_cfg_wdata;
        end
    end

    // Capture the item; the target cell is the cursor or the saturated position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_item.kind;
            r_char <= i_item.character;
            r_attr <= i_item.attribute;
            if (i_item.kind == KIND_PUT) begin
                r_tcol <= r_cur_col;
                r_trow <= r_cur_row;
            end else begin
                r_tcol <= (32'(i_item.column) >= 32'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                              : COL_W'(i_item.column);
                r_trow <= (32'(i_item.row) >= 32'(ROWS)) ? ROW_W'(ROWS - 1)
                                                        : ROW_W'(i_item.row);
            end
        end
        if (i_cmd.calc_addr) begin
            r_addr <= ADDR_W'(32'(r_trow) * 32'(COLUMNS) + 32'(r_tcol));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.sweep_fill) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.put) begin
            if (wrap_col) begin
                r_cur_col <= '0;
                r_cur_row <= last_row ? r_trow : r_trow + ROW_W'(1);
            end else begin
                r_cur_col <= r_tcol + COL_W'(1);
                r_cur_row <= r_trow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= '0;
            r_sc_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep_fill || i_cmd.scroll) begin
                r_sweep <= sweep_last ? '0 : r_sweep + ADDR_W'(1);
            end
            r_sc_valid <= i_cmd.scroll;
        end
    end

    // Each scroll write lands in the cycle after its read; the last row takes zeros.
    always_ff @(posedge i_clk) begin
        r_sc_addr <= r_sweep;
        r_sc_zero <= !sweep_moves;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_attr, r_char};
        if (i_cmd.sweep_fill) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep;
            mem_wdata = i_cmd.fill_clear ? {r_clear_attr, SPACE_CODE} : 16'h0000;
        end else if (i_cmd.put && (r_char != NEWLINE_CODE)) begin
            mem_we = 1'b1;
        end else if (r_sc_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_sc_addr;
            mem_wdata = r_sc_zero ? 16'h0000 : r_rdata;
        end
    end

    always_comb begin
        mem_raddr = r_addr;
        if (i_cmd.scroll) begin
            mem_raddr = sweep_moves ? ADDR_W'(32'(r_sweep) + 32'(COLUMNS)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.cursor_cell <= 11'(32'(r_cur_row) * 32'(COLUMNS) + 32'(r_cur_col));
            if (r_kind == KIND_READ) begin
                r_out.read_character <= r_rdata[7:0];
                r_out.read_attribute <= r_rdata[15:8];
            end else begin
                r_out.read_character <= '0;
                r_out.read_attribute <= '0;
            end
        end
    end

    assign o_item = r_out;

endmodule

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// Character-cell text console with a cursor, ROWS by COLUMNS cells in a
// single-port-write, registered-read memory. A put at the cursor or at a
// column/row steps through capture, address multiply, cell write and result
// load; a put that wraps or takes a newline on the last row adds a scroll,
// one cell moved per cycle through the memory port. Clear writes one cell per
// cycle; a read steps through capture, address multiply, memory read and
// result load. After reset the block zeroes the memory with stall high;
// configuration writes are taken throughout. The result register lets the
// next item in while a result still waits to be taken.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

/* rtl/tcw_checker.sv */
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input t_out_item  o_item
);

    localparam int CELLS = COLUMNS * ROWS;

    `TCW_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `TCW_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_item))
    // One transaction at a time: intake closes right after an accept.
    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `TCW_ASSERT_SAME(a_cursor_in_range, i_clk, i_rst_n, o_valid,
        (CELLS > 2048) || (32'(o_item.cursor_cell) < 32'(CELLS)))

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (.*);
